// ----- hw/rtl/twc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_pkg
// Shared types, register codes and constants for the connection throttle.
// ----------------------------------------------------------------------------
package twc_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int RING_DEPTH_DEF = 256;
    localparam int RATE_FRAC_DEF  = 16;

    // Fixed field widths
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 16;
    localparam int WINDOW_W   = 9;
    localparam int POWER_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_VW     = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Register reset values
    localparam logic                  ENABLE_RST = 1'b1;
    localparam logic [WINDOW_W-1:0]   WINDOW_RST = 9'd240;
    localparam logic [CNT_W-1:0]      LIMIT_RST  = 16'd16384;
    localparam logic [POWER_W-1:0]    POWER_RST  = 4'd2;
    localparam logic [CNT_W-1:0]      MAXW_RST   = 16'd1000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 3'd0,
        CFG_WINDOW   = 3'd1,
        CFG_LIMIT    = 3'd2,
        CFG_POWER    = 3'd3,
        CFG_MAX_WAIT = 3'd4
    } t_cfg_idx;

    // Event kinds
    typedef enum logic {
        EVT_CONNECT    = 1'b0,
        EVT_DISCONNECT = 1'b1
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BACKWARDS = 2'd1,
        STAT_NO_OPEN   = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_MOD,
        ST_MOD_WAIT,
        ST_IDLE,
        ST_START,
        ST_CU_CHECK,
        ST_CU_SUB,
        ST_JUMP_WAIT,
        ST_EVENT,
        ST_DISC_WR,
        ST_DIV_WAIT,
        ST_POW,
        ST_POW_ACC,
        ST_WAIT_ACC,
        ST_FINISH
    } t_state;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- hw/rtl/twc_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_in_if
// Event channel: valid/ready handshake with event kind and time stamp.
// ----------------------------------------------------------------------------
interface twc_in_if;
    import twc_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [TIME_W-1:0] now_seconds;

    modport source (output valid, output kind, output now_seconds, input ready);
    modport sink   (input valid, input kind, input now_seconds, output ready);
endinterface

// ----- hw/rtl/twc_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_out_if
// Result channel: valid/ready handshake with wait, counts and status.
// ----------------------------------------------------------------------------
interface twc_out_if;
    import twc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CNT_W-1:0]    wait_ms;
    logic [CNT_W-1:0]    busy_ports;
    logic [CNT_W-1:0]    time_wait_count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output wait_ms, output busy_ports,
                    output time_wait_count, output status, input ready);
    modport sink   (input valid, input wait_ms, input busy_ports,
                    input time_wait_count, input status, output ready);
endinterface

// ----- hw/rtl/twc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module twc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/twc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_div
// Restoring divider, one quotient bit per cycle. Shared for the ring
// position (time modulo window) and the busy rate (busy / limit).
// ----------------------------------------------------------------------------
module twc_div #(
    parameter int DW = 32,
    parameter int VW = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DW-1:0]       i_dividend,
    input  logic [VW-1:0]       i_divisor,
    output twc_pkg::t_div_stat  o_stat,
    output logic [DW-1:0]       o_quot,
    output logic [VW-1:0]       o_rem
);
    import twc_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;

    logic [VW:0]   trial;
    logic          fits;

    // One restoring step: shift in the next dividend bit, try to subtract
    assign trial = {r_rem, r_quo[DW-1]};
    assign fits  = (trial >= {1'b0, r_div});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? VW'(trial - {1'b0, r_div}) : trial[VW-1:0];
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;
    assign o_rem       = r_rem;

`ifndef ASSERT_OFF
    // A finished division leaves a remainder below a nonzero divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_div != '0) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ----- hw/rtl/time_wait_connection_throttle_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_wait_connection_throttle_top
// Counts open and time-wait ports over a ring of per-second buckets and
// returns a throttle wait for each connect event.
// ----------------------------------------------------------------------------
// Usage:
//   i_evt carries one event (kind, now_seconds); o_res returns exactly one
//   result per event. The user writes registers through i_cfg_we/index/data
//   only while the block is idle (the block does not enforce it); a window
//   write zeroes the time-wait total and starts a bucket clearing pass.
// Sequence:
//   Disabled or backwards-time events go straight to the result.
//   Catch-up reads, subtracts and clears one bucket per elapsed second walked
//   (at most one window); a jump to the current second divides for the ring position.
//   A connect runs the rate division (skipped when the busy count reaches
//   the limit), then the power steps and the scaling by the max wait.
//   A disconnect adds a bucket update.
//   The worst case is set by the bucket walk through the single ring RAM
//   and the serial DW-bit divider, with DW = max(32, 16 + RATE_FRACTION_BITS).
// Reset: a clearing pass over all RING_DEPTH entries, then the ring position
//   division; i_evt ready stays low meanwhile.
// Stall: the result waits in the output register; one more event can be
//   taken and worked on, and it completes once the register is free.
// ----------------------------------------------------------------------------
module time_wait_connection_throttle_top #(
    parameter int RING_DEPTH         = twc_pkg::RING_DEPTH_DEF,
    parameter int RATE_FRACTION_BITS = twc_pkg::RATE_FRAC_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    twc_in_if.sink                          i_evt,
    twc_out_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [twc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [twc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import twc_pkg::*;

    localparam int F    = RATE_FRACTION_BITS;
    localparam int AW   = $clog2(RING_DEPTH);
    localparam int WINW = $clog2(RING_DEPTH + 1);
    localparam int DW   = (CNT_W + F > TIME_W) ? CNT_W + F : TIME_W;
    localparam int PW   = F + 1;
    localparam int MW   = (PW > CNT_W) ? PW : CNT_W;
    localparam int PRW  = PW + MW;

    localparam logic [PW-1:0]  ONE  = PW'(1) << F;
    localparam logic [PRW-1:0] HALF = PRW'(1) << (F - 1);

    // Configuration registers
    logic                r_enable;
    logic [WINDOW_W-1:0] r_window;
    logic [CNT_W-1:0]    r_limit;
    logic [POWER_W-1:0]  r_power;
    logic [CNT_W-1:0]    r_maxw;

    // Sequencer state and datapath registers
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic [TIME_W-1:0] r_last, n_last;
    logic [AW-1:0]     r_pos, n_pos;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [CNT_W-1:0]  r_open, n_open;
    logic [WINW-1:0]   r_steps, n_steps;
    logic              r_kind, n_kind;
    logic [TIME_W-1:0] r_now, n_now;
    logic [CNT_W-1:0]  r_wait, n_wait;
    t_status           r_status, n_status;
    logic [PW-1:0]     r_rate, n_rate;
    logic [PW-1:0]     r_p, n_p;
    logic [POWER_W-1:0] r_pow_cnt, n_pow_cnt;
    logic [PRW-1:0]    r_prod, n_prod;

    // Output register
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_out_wait;
    logic [CNT_W-1:0]    r_out_busy;
    logic [CNT_W-1:0]    r_out_tw;
    t_status             r_out_status;
    logic                load_out;

    // Shared units
    logic              div_start;
    logic [DW-1:0]     div_dividend;
    logic [DIV_VW-1:0] div_divisor;
    t_div_stat         div_stat;
    logic [DW-1:0]     div_quot;
    logic [DIV_VW-1:0] div_rem;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CNT_W-1:0]  ram_rdata;

    logic [WINW-1:0]   win;
    logic [WINW-1:0]   pos_inc;
    logic [AW-1:0]     next_pos;
    logic [CNT_W:0]    busy_sum;
    logic [CNT_W-1:0]  busy_now;
    logic [CNT_W-1:0]  lim;
    logic              mul_use_max;
    logic [MW-1:0]     mul_b;
    logic [PRW-1:0]    mul_prod;
    logic              win_write;

    // Effective window: zero acts as one, clamp to the ring depth
    always_comb begin
        if (r_window == '0) begin
            win = WINW'(1);
        end else if (32'(r_window) > 32'(RING_DEPTH)) begin
            win = WINW'(RING_DEPTH);
        end else begin
            win = WINW'(r_window);
        end
    end

    // Ring position step with wrap at the window
    assign pos_inc  = WINW'(r_pos) + WINW'(1);
    assign next_pos = (pos_inc == win) ? '0 : AW'(pos_inc);

    // Saturated busy count and effective limit
    assign busy_sum = (CNT_W + 1)'(r_open) + (CNT_W + 1)'(r_total);
    assign busy_now = busy_sum[CNT_W] ? CNT_MAX : busy_sum[CNT_W-1:0];
    assign lim      = (r_limit == '0) ? CNT_W'(1) : r_limit;

    // Shared multiplier: power steps use the rate, the last step the max wait
    assign mul_use_max = (r_pow_cnt == r_power);
    assign mul_b       = mul_use_max ? MW'(r_maxw) : MW'(r_rate);
    assign mul_prod    = r_p * mul_b;

    assign win_write = i_cfg_we && (i_cfg_index == CFG_WINDOW);

    twc_div #(
        .DW (DW),
        .VW (DIV_VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    twc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= ENABLE_RST;
            r_window <= WINDOW_RST;
            r_limit  <= LIMIT_RST;
            r_power  <= POWER_RST;
            r_maxw   <= MAXW_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:   r_enable <= i_cfg_data[0];
                CFG_WINDOW:   r_window <= i_cfg_data[WINDOW_W-1:0];
                CFG_LIMIT:    r_limit  <= i_cfg_data[CNT_W-1:0];
                CFG_POWER:    r_power  <= i_cfg_data[POWER_W-1:0];
                CFG_MAX_WAIT: r_maxw   <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: next state and datapath
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_last       = r_last;
        n_pos        = r_pos;
        n_total      = r_total;
        n_open       = r_open;
        n_steps      = r_steps;
        n_kind       = r_kind;
        n_now        = r_now;
        n_wait       = r_wait;
        n_status     = r_status;
        n_rate       = r_rate;
        n_p          = r_p;
        n_pow_cnt    = r_pow_cnt;
        n_prod       = r_prod;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        ram_we       = 1'b0;
        ram_waddr    = r_pos;
        ram_wdata    = '0;
        ram_raddr    = r_pos;
        load_out     = 1'b0;

        unique case (r_state)
            // Zero the ring one entry a cycle
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                if (r_clr_addr == AW'(RING_DEPTH - 1)) begin
                    n_state = ST_MOD;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            // Ring position = last second modulo window
            ST_MOD: begin
                div_start    = 1'b1;
                div_dividend = DW'(r_last);
                div_divisor  = DIV_VW'(win);
                n_state      = ST_MOD_WAIT;
            end
            ST_MOD_WAIT: begin
                if (div_stat.done) begin
                    n_pos   = AW'(div_rem);
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_evt.valid) begin
                    n_kind  = i_evt.kind;
                    n_now   = i_evt.now_seconds;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_wait   = '0;
                n_status = STAT_OK;
                n_steps  = '0;
                if (!r_enable) begin
                    n_state = ST_FINISH;
                end else if (r_now < r_last) begin
                    n_status = STAT_BACKWARDS;
                    n_state  = ST_FINISH;
                end else begin
                    n_state = ST_CU_CHECK;
                end
            end
            // Catch-up: one second per pass, or jump once the total is empty or a full window is walked
            ST_CU_CHECK: begin
                if (r_last < r_now) begin
                    if (r_total == '0 || r_steps >= win) begin
                        n_last       = r_now;
                        div_start    = 1'b1;
                        div_dividend = DW'(r_now);
                        div_divisor  = DIV_VW'(win);
                        n_state      = ST_JUMP_WAIT;
                    end else begin
                        n_last    = r_last + TIME_W'(1);
                        n_steps   = r_steps + WINW'(1);
                        n_pos     = next_pos;
                        ram_raddr = next_pos;
                        n_state   = ST_CU_SUB;
                    end
                end else begin
                    n_state = ST_EVENT;
                end
            end
            ST_CU_SUB: begin
                n_total   = (r_total >= ram_rdata) ? r_total - ram_rdata : '0;
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = '0;
                n_state   = ST_CU_CHECK;
            end
            ST_JUMP_WAIT: begin
                if (div_stat.done) begin
                    n_pos   = AW'(div_rem);
                    n_state = ST_EVENT;
                end
            end
            ST_EVENT: begin
                if (r_kind == EVT_CONNECT) begin
                    n_p       = ONE;
                    n_pow_cnt = '0;
                    if (r_open != CNT_MAX) begin
                        n_open = r_open + CNT_W'(1);
                    end
                    if (busy_now >= lim) begin
                        n_rate  = ONE;
                        n_state = ST_POW;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = DW'(busy_now) << F;
                        div_divisor  = DIV_VW'(lim);
                        n_state      = ST_DIV_WAIT;
                    end
                end else if (r_open == '0) begin
                    n_status = STAT_NO_OPEN;
                    n_state  = ST_FINISH;
                end else begin
                    n_open = r_open - CNT_W'(1);
                    if (r_total != CNT_MAX) begin
                        n_total   = r_total + CNT_W'(1);
                        ram_raddr = r_pos;
                        n_state   = ST_DISC_WR;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            // Bump the current second's bucket
            ST_DISC_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = ram_rdata + CNT_W'(1);
                n_state   = ST_FINISH;
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    n_rate  = PW'(div_quot);
                    n_state = ST_POW;
                end
            end
            // Power loop, then scale by the max wait
            ST_POW: begin
                n_prod = mul_prod;
                if (mul_use_max) begin
                    n_state = ST_WAIT_ACC;
                end else begin
                    n_pow_cnt = r_pow_cnt + POWER_W'(1);
                    n_state   = ST_POW_ACC;
                end
            end
            ST_POW_ACC: begin
                n_p     = PW'((r_prod + HALF) >> F);
                n_state = ST_POW;
            end
            ST_WAIT_ACC: begin
                n_wait  = CNT_W'((r_prod + HALF) >> F);
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || o_res.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Window rewrite: drop all time-wait state and sweep the ring
        if (win_write) begin
            n_total    = '0;
            n_clr_addr = '0;
            n_state    = ST_CLEAR;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_last     <= '0;
            r_pos      <= '0;
            r_total    <= '0;
            r_open     <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_last     <= n_last;
            r_pos      <= n_pos;
            r_total    <= n_total;
            r_open     <= n_open;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_steps   <= n_steps;
        r_kind    <= n_kind;
        r_now     <= n_now;
        r_wait    <= n_wait;
        r_status  <= n_status;
        r_rate    <= n_rate;
        r_p       <= n_p;
        r_pow_cnt <= n_pow_cnt;
        r_prod    <= n_prod;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_wait   <= r_wait;
            r_out_busy   <= busy_now;
            r_out_tw     <= r_total;
            r_out_status <= r_status;
        end
    end

    assign i_evt.ready           = (r_state == ST_IDLE);
    assign o_res.valid           = r_out_valid;
    assign o_res.wait_ms         = r_out_wait;
    assign o_res.busy_ports      = r_out_busy;
    assign o_res.time_wait_count = r_out_tw;
    assign o_res.status          = r_out_status;

`ifndef ASSERT_OFF
    // Ring position stays inside the window between events
    a_pos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (WINW'(r_pos) < win))
        else $error("ring position outside window");

    // Time stamp of the ring never moves backwards
    a_last_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_last >= $past(r_last)))
        else $error("last second moved backwards");

    // Catch-up only drains the time-wait total
    a_drain_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CU_SUB) |=> (r_total <= $past(r_total)))
        else $error("time-wait total grew during catch-up");

    // Divider is never restarted mid-division
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A finished event always lands in the output register
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && !win_write && (!r_out_valid || o_res.ready))
        |=> r_out_valid)
        else $error("finished result not presented");
`endif

endmodule
